// File: hdl/ssd_pkg.sv
// Shared definitions for the seven-segment two-wire frame driver.
// Holds command bytes, item codes, the result struct and the hex-to-segment encoder.
// No dependencies.
package ssd_pkg;

  localparam int DIGIT_COUNT_DEF = 4;
  localparam int DIGIT_PORTS = 4;

  localparam logic FUNC_REQ  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [7:0] CMD_DATA = 8'h40;
  localparam logic [7:0] CMD_ADDR = 8'hC0;
  localparam logic [7:0] CMD_CTRL = 8'h80;
  localparam logic [7:0] DOT_BIT  = 8'h80;

  typedef struct packed {
    logic clk_pull_low;
    logic dio_pull_low;
    logic busy_res;
    logic ack_level;
    logic transfer_end;
  } res_t;

  // Bit 0 is segment A through bit 6 segment G.
  function automatic logic [7:0] seg_encode(input logic [3:0] hex);
    logic [7:0] seg;
    case (hex)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h6F;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      default: seg = 8'h71;
    endcase
    return seg;
  endfunction

endpackage

// File: hdl/seven_segment_two_wire_frame_driver.sv
// Seven-segment hex display driver that sends three open-drain two-wire frames per request.
// Takes one item per clock whenever full is low; each item gives exactly one result, which
// passes through the input queue and then through the sequencer into the result queue before it
// can be popped. The rate is set by the one-slot-per-item sequencer in ssd_back; when the result
// queue is full the sequencer waits and full rises once the input queue holds two items.
// A request latches four digits and the dot flag; each tick moves the bus by one bit-delay slot.
// Requests that arrive during a transfer are ignored but still answered. Depends on ssd_pkg,
// ssd_fifo, ssd_front and ssd_back.
module seven_segment_two_wire_frame_driver #(
  parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       func,
  input  logic [3:0] digit_a,
  input  logic [3:0] digit_b,
  input  logic [3:0] digit_c,
  input  logic [3:0] digit_d,
  input  logic       colon_on,
  input  logic       dio_level,
  input  logic       cfg_write,
  input  logic [3:0] cfg_data,
  output logic       empty,
  input  logic       pop,
  output logic       clk_pull_low,
  output logic       dio_pull_low,
  output logic       busy_res,
  output logic       ack_level,
  output logic       transfer_end
);
  import ssd_pkg::*;

  localparam int ITEM_W = 2 + 8 * DIGIT_COUNT;

  logic              item_valid;
  logic [ITEM_W-1:0] item;
  logic              item_take;
  res_t              res;

  ssd_front #(.DIGIT_COUNT(DIGIT_COUNT), .ITEM_W(ITEM_W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .digit_a    (digit_a),
    .digit_b    (digit_b),
    .digit_c    (digit_c),
    .digit_d    (digit_d),
    .colon_on   (colon_on),
    .dio_level  (dio_level),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  ssd_back #(.DIGIT_COUNT(DIGIT_COUNT), .ITEM_W(ITEM_W)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .empty      (empty),
    .pop        (pop),
    .res        (res)
  );

  assign clk_pull_low = res.clk_pull_low;
  assign dio_pull_low = res.dio_pull_low;
  assign busy_res     = res.busy_res;
  assign ack_level    = res.ack_level;
  assign transfer_end = res.transfer_end;

endmodule

// File: hdl/ssd_fifo.sv
// Two-entry first-in first-out queue built from two registers.
// Used between the front and back parts and on the result side; no dependencies.
module ssd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [1:0][WIDTH-1:0] ent;
  logic [1:0] count;
  logic wpos;
  logic do_push;
  logic do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  // A push lands in the upper entry only when one item stays behind in the lower one.
  assign wpos    = count[0] && !do_pop;
  assign rdata   = ent[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !wpos) begin
      ent[0] <= wdata;
    end else if (do_pop) begin
      ent[0] <= ent[1];
    end
    if (do_push && wpos) begin
      ent[1] <= wdata;
    end
  end

endmodule

// File: hdl/ssd_front.sv
// Front part: accepts input items, encodes the digits into segment bytes and queues them.
// Depends on ssd_pkg and ssd_fifo.
module ssd_front #(
  parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF,
  parameter int ITEM_W = 2 + 8 * DIGIT_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              func,
  input  logic [3:0]        digit_a,
  input  logic [3:0]        digit_b,
  input  logic [3:0]        digit_c,
  input  logic [3:0]        digit_d,
  input  logic              colon_on,
  input  logic              dio_level,
  output logic              item_valid,
  output logic [ITEM_W-1:0] item,
  input  logic              item_take
);
  import ssd_pkg::*;

  typedef struct packed {
    logic                        func;
    logic                        dio_level;
    logic [DIGIT_COUNT-1:0][7:0] segs;
  } item_t;

  item_t cls;
  logic [DIGIT_PORTS-1:0][3:0] digits;
  logic q_empty;

  assign digits = {digit_d, digit_c, digit_b, digit_a};

  // Positions past the fourth go out blank; the dot only exists on position one.
  always_comb begin
    cls.func      = func;
    cls.dio_level = dio_level;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (i < DIGIT_PORTS) begin
        cls.segs[i] = seg_encode(digits[i % DIGIT_PORTS]);
      end else begin
        cls.segs[i] = 8'h00;
      end
      if (i == 1 && colon_on) begin
        cls.segs[i] = cls.segs[i] | DOT_BIT;
      end
    end
  end

  ssd_fifo #(.WIDTH(ITEM_W)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (item_take),
    .rdata (item),
    .empty (q_empty)
  );

  assign item_valid = !q_empty;

endmodule

// File: hdl/ssd_back.sv
// Back part: the frame sequencer that moves one bit-delay slot per tick item.
// Depends on ssd_pkg and ssd_fifo; results leave through a two-entry queue.
module ssd_back #(
  parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF,
  parameter int ITEM_W = 2 + 8 * DIGIT_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [ITEM_W-1:0] item,
  output logic              item_take,
  input  logic              cfg_write,
  input  logic [3:0]        cfg_data,
  output logic              empty,
  input  logic              pop,
  output ssd_pkg::res_t     res
);
  import ssd_pkg::*;

  localparam int BW = $clog2(DIGIT_COUNT + 2);
  localparam logic [BW-1:0] ADDR_FRAME_BYTES = BW'(DIGIT_COUNT + 1);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_BYTES = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;

  localparam logic [1:0] FR_DATA = 2'd0;
  localparam logic [1:0] FR_ADDR = 2'd1;
  localparam logic [1:0] FR_CTRL = 2'd2;

  localparam logic [4:0] SLOT_ACK_LOW  = 5'd24;
  localparam logic [4:0] SLOT_ACK_SAMP = 5'd25;
  localparam logic [4:0] SLOT_ACK_HOLD = 5'd26;
  localparam logic [4:0] SLOT_LAST     = 5'd27;

  typedef struct packed {
    logic                        func;
    logic                        dio_level;
    logic [DIGIT_COUNT-1:0][7:0] segs;
  } item_t;

  item_t in_item;
  logic out_full;

  logic [3:0] brightness;
  logic busy, busy_next;
  logic [1:0] phase, phase_next;
  logic [1:0] frame_index, frame_index_next;
  logic [BW-1:0] byte_index, byte_index_next;
  logic [BW-1:0] byte_inc;
  logic [4:0] slot, slot_next;
  logic [1:0] sub, sub_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [DIGIT_COUNT-1:0][7:0] segs, segs_next;
  logic last_ack, last_ack_next;
  logic clk_low, clk_low_next;
  logic dio_low, dio_low_next;
  logic xfer_end;
  logic [BW-1:0] frame_bytes;
  res_t res_in;

  assign in_item   = item;
  assign item_take = item_valid && !out_full;
  assign byte_inc  = byte_index + BW'(1);
  assign frame_bytes = (frame_index == FR_ADDR) ? ADDR_FRAME_BYTES : BW'(1);

  function automatic logic [7:0] pick_byte(input logic [1:0] fr, input logic [BW-1:0] bi,
                                           input logic [DIGIT_COUNT-1:0][7:0] sb,
                                           input logic [3:0] br);
    logic [7:0] b;
    b = 8'h00;
    if (fr == FR_DATA) begin
      b = CMD_DATA;
    end else if (fr == FR_ADDR) begin
      if (bi == BW'(0)) begin
        b = CMD_ADDR;
      end else begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          if (bi == BW'(i + 1)) begin
            b = sb[i];
          end
        end
      end
    end else begin
      b = CMD_CTRL | {4'h0, br};
    end
    return b;
  endfunction

  always_comb begin
    busy_next        = busy;
    phase_next       = phase;
    frame_index_next = frame_index;
    byte_index_next  = byte_index;
    slot_next        = slot;
    sub_next         = sub;
    shift_byte_next  = shift_byte;
    segs_next        = segs;
    last_ack_next    = last_ack;
    clk_low_next     = clk_low;
    dio_low_next     = dio_low;
    xfer_end         = 1'b0;
    if (in_item.func == FUNC_REQ) begin
      if (!busy) begin
        segs_next        = in_item.segs;
        busy_next        = 1'b1;
        frame_index_next = FR_DATA;
        byte_index_next  = '0;
        slot_next        = 5'd0;
        sub_next         = 2'd0;
        phase_next       = PH_START;
      end
    end else if (busy) begin
      case (phase)
        PH_START: begin
          dio_low_next    = 1'b1;
          phase_next      = PH_BYTES;
          byte_index_next = '0;
          slot_next       = 5'd0;
          sub_next        = 2'd0;
          shift_byte_next = pick_byte(frame_index, '0, segs, brightness);
        end
        PH_BYTES: begin
          if (slot < SLOT_ACK_LOW) begin
            // Each data bit takes three slots: clock low, data set, clock release.
            case (sub)
              2'd0: clk_low_next = 1'b1;
              2'd1: dio_low_next = !shift_byte[0];
              default: begin
                clk_low_next    = 1'b0;
                shift_byte_next = {1'b0, shift_byte[7:1]};
              end
            endcase
            sub_next = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
          end else if (slot == SLOT_ACK_LOW) begin
            clk_low_next = 1'b1;
            dio_low_next = 1'b0;
          end else if (slot == SLOT_ACK_SAMP) begin
            clk_low_next  = 1'b0;
            last_ack_next = in_item.dio_level;
          end else if (slot == SLOT_ACK_HOLD) begin
            if (!last_ack) begin
              dio_low_next = 1'b1;
            end
          end else begin
            clk_low_next = 1'b1;
          end
          if (slot >= SLOT_LAST) begin
            slot_next       = 5'd0;
            sub_next        = 2'd0;
            byte_index_next = byte_inc;
            if (byte_inc < frame_bytes) begin
              shift_byte_next = pick_byte(frame_index, byte_inc, segs, brightness);
            end else begin
              phase_next = PH_STOP;
            end
          end else begin
            slot_next = slot + 5'd1;
          end
        end
        default: begin
          if (slot == 5'd0) begin
            dio_low_next = 1'b1;
          end else if (slot == 5'd1) begin
            clk_low_next = 1'b0;
          end else begin
            dio_low_next = 1'b0;
          end
          if (slot >= 5'd2) begin
            slot_next  = 5'd0;
            phase_next = PH_START;
            if (frame_index >= FR_CTRL) begin
              frame_index_next = FR_DATA;
              busy_next        = 1'b0;
              xfer_end         = 1'b1;
            end else begin
              frame_index_next = frame_index + 2'd1;
            end
          end else begin
            slot_next = slot + 5'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness  <= 4'd15;
      busy        <= 1'b0;
      phase       <= PH_START;
      frame_index <= FR_DATA;
      byte_index  <= '0;
      slot        <= 5'd0;
      sub         <= 2'd0;
      shift_byte  <= 8'h00;
      last_ack    <= 1'b0;
      clk_low     <= 1'b0;
      dio_low     <= 1'b0;
    end else begin
      if (cfg_write) begin
        brightness <= cfg_data;
      end
      if (item_take) begin
        busy        <= busy_next;
        phase       <= phase_next;
        frame_index <= frame_index_next;
        byte_index  <= byte_index_next;
        slot        <= slot_next;
        sub         <= sub_next;
        shift_byte  <= shift_byte_next;
        last_ack    <= last_ack_next;
        clk_low     <= clk_low_next;
        dio_low     <= dio_low_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      segs <= segs_next;
    end
  end

  always_comb begin
    res_in.clk_pull_low = clk_low_next;
    res_in.dio_pull_low = dio_low_next;
    res_in.busy_res     = busy_next;
    res_in.ack_level    = last_ack_next;
    res_in.transfer_end = xfer_end;
  end

  ssd_fifo #(.WIDTH($bits(res_t))) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (item_take),
    .wdata (res_in),
    .full  (out_full),
    .pop   (pop),
    .rdata (res),
    .empty (empty)
  );

  a_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (phase == PH_START && frame_index == FR_DATA))
    else $error("idle sequencer is not parked at the first frame start");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BYTES) |-> (slot <= SLOT_LAST && byte_index < frame_bytes))
    else $error("byte slot or byte index out of range");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && $past(!rst)) |->
      $past(item_take && in_item.func == FUNC_TICK && phase == PH_STOP &&
            frame_index == FR_CTRL))
    else $error("transfer ended outside the last stop slot");

  a_end_not_busy: assert property (@(posedge clk) disable iff (rst)
    (item_take && xfer_end) |=> !busy)
    else $error("busy still set after transfer end");

endmodule
